// ----- rtl/meta_tile_map_write_generator_unit_defines.svh -----
// Assertion macros used by the back walker of the meta-tile map write generator.
`ifndef META_TILE_MAP_WRITE_GENERATOR_UNIT_DEFINES_SVH
`define META_TILE_MAP_WRITE_GENERATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked on clk, off while rst_n is low.
`define MTMWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication form of the same check.
`define MTMWG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MTMWG_ASSERT(lbl, prop, msg)
`define MTMWG_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/mtmwg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtmwg_pkg
// Types, register indexes and helpers of the meta-tile map write generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtmwg_pkg;

  localparam int QUAD_TILES  = 32;
  localparam int QUAD_BITS   = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TILES_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD    = 2'd2;

  localparam logic [3:0] MAX_SUB = 4'd8;

  typedef struct packed {
    logic [9:0] meta_number;
    logic [5:0] meta_col;
    logic [5:0] meta_row;
  } req_t;

  typedef struct packed {
    logic [11:0] entry_address;
    logic [9:0]  tile_number;
    logic        last_write;
  } res_t;

  // One classified request, as handed from front to back.
  typedef struct packed {
    logic [5:0] base_col;
    logic [5:0] base_row;
    logic [9:0] start_tile;
    logic [2:0] tx_m1;
    logic [2:0] ty_m1;
    logic       quad_layout;
  } entry_t;

  function automatic logic [3:0] clamp_count(input logic [3:0] v);
    logic [3:0] r;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > MAX_SUB) begin
      r = MAX_SUB;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mtmwg_front.sv -----
// ----------------------------------------------------------------------------
// mtmwg_front
// Accepts a draw request, works out the wrapped base position and first tile.
// ----------------------------------------------------------------------------
`default_nettype none

module mtmwg_front #(
  parameter int MAP_TILES_X = 64,
  parameter int MAP_TILES_Y = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mtmwg_pkg::req_t   in_data,
  input  wire logic [3:0]        tiles_x,
  input  wire logic [3:0]        tiles_y,
  input  wire logic              quad_layout,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output mtmwg_pkg::entry_t      push_data
);
  import mtmwg_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_WRAP} fstate_t;

  localparam logic [8:0] MAP_X9 = 9'(MAP_TILES_X);
  localparam logic [8:0] MAP_Y9 = 9'(MAP_TILES_Y);

  fstate_t     state_r;
  logic [9:0]  num_r;
  logic [5:0]  mc_r;
  logic [5:0]  mr_r;
  logic [3:0]  tx_r;
  logic [3:0]  ty_r;
  logic [6:0]  total_r;
  logic        layout_r;
  logic [8:0]  col_r;
  logic [8:0]  row_r;
  logic [9:0]  tile_r;
  logic [3:0]  tx_c;
  logic [3:0]  ty_c;
  logic        col_ok;
  logic        row_ok;

  assign tx_c     = clamp_count(tiles_x);
  assign ty_c     = clamp_count(tiles_y);
  assign col_ok   = col_r < MAP_X9;
  assign row_ok   = row_r < MAP_Y9;
  assign in_ready = (state_r == F_IDLE);

  assign push_valid            = (state_r == F_WRAP) && col_ok && row_ok;
  assign push_data.base_col    = col_r[5:0];
  assign push_data.base_row    = row_r[5:0];
  assign push_data.start_tile  = tile_r;
  assign push_data.tx_m1       = 3'(tx_r - 4'd1);
  assign push_data.ty_m1       = 3'(ty_r - 4'd1);
  assign push_data.quad_layout = layout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            num_r    <= in_data.meta_number;
            mc_r     <= in_data.meta_col;
            mr_r     <= in_data.meta_row;
            tx_r     <= tx_c;
            ty_r     <= ty_c;
            total_r  <= 7'(tx_c) * 7'(ty_c);
            layout_r <= quad_layout;
            state_r  <= F_MUL;
          end
        end
        F_MUL: begin
          col_r   <= 9'(mc_r) * 9'(tx_r);
          row_r   <= 9'(mr_r) * 9'(ty_r);
          tile_r  <= num_r * 10'(total_r);
          state_r <= F_WRAP;
        end
        F_WRAP: begin
          // wrap one map width or height per cycle until both coordinates fit
          if (!col_ok) begin
            col_r <= col_r - MAP_X9;
          end
          if (!row_ok) begin
            row_r <= row_r - MAP_Y9;
          end
          if (push_valid && push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mtmwg_queue.sv -----
// ----------------------------------------------------------------------------
// mtmwg_queue
// Two-entry queue between the request front and the write back part.
// ----------------------------------------------------------------------------
`default_nettype none

module mtmwg_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire mtmwg_pkg::entry_t  push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output mtmwg_pkg::entry_t       pop_data
);
  import mtmwg_pkg::*;

  entry_t             slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= QPTR_W'((32'(wr_ptr_r) + 1) % QUEUE_DEPTH);
      end
      if (do_pop) begin
        rd_ptr_r <= QPTR_W'((32'(rd_ptr_r) + 1) % QUEUE_DEPTH);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mtmwg_back.sv -----
// ----------------------------------------------------------------------------
// mtmwg_back
// Walks one meta-tile row-major and issues one map write per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "meta_tile_map_write_generator_unit_defines.svh"

module mtmwg_back #(
  parameter int MAP_TILES_X  = 64,
  parameter int MAP_TILES_Y  = 64,
  parameter int QUADS_ACROSS = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire mtmwg_pkg::entry_t  pop_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mtmwg_pkg::res_t         out_data
);
  import mtmwg_pkg::*;

  localparam logic [6:0]  MAP_X7  = 7'(MAP_TILES_X);
  localparam logic [6:0]  MAP_Y7  = 7'(MAP_TILES_Y);
  localparam logic [11:0] MAP_X12 = 12'(MAP_TILES_X);
  localparam logic [11:0] QA12    = 12'(QUADS_ACROSS);

  logic        act_r;
  entry_t      ent_r;
  logic [2:0]  x_r;
  logic [2:0]  y_r;
  logic [9:0]  tile_r;
  logic        out_valid_r;
  res_t        out_data_r;

  logic        emit;
  logic        last;
  logic        load;
  logic [6:0]  hx_sum;
  logic [6:0]  hy_sum;
  logic [5:0]  hx;
  logic [5:0]  hy;
  logic [11:0] addr_lin;
  logic [11:0] quad;
  logic [11:0] addr_quad;

  assign emit = act_r && (!out_valid_r || out_ready);
  assign last = (x_r == ent_r.tx_m1) && (y_r == ent_r.ty_m1);
  assign load = !act_r || (emit && last);
  assign pop_ready = load;

  // base is already inside the map, so one subtract wraps the offset sum
  assign hx_sum = 7'(ent_r.base_col) + 7'(x_r);
  assign hy_sum = 7'(ent_r.base_row) + 7'(y_r);
  assign hx     = (hx_sum >= MAP_X7) ? 6'(hx_sum - MAP_X7) : hx_sum[5:0];
  assign hy     = (hy_sum >= MAP_Y7) ? 6'(hy_sum - MAP_Y7) : hy_sum[5:0];

  assign addr_lin  = 12'(hy) * MAP_X12 + 12'(hx);
  assign quad      = 12'(hy >> QUAD_BITS) * QA12 + 12'(hx >> QUAD_BITS);
  assign addr_quad = (quad << (2 * QUAD_BITS))
                   + (12'(hy[QUAD_BITS-1:0]) << QUAD_BITS)
                   + 12'(hx[QUAD_BITS-1:0]);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.entry_address <= ent_r.quad_layout ? addr_quad : addr_lin;
      out_data_r.tile_number   <= tile_r;
      out_data_r.last_write    <= last;
    end
    if (load && pop_valid) begin
      ent_r  <= pop_data;
      tile_r <= pop_data.start_tile;
      x_r    <= '0;
      y_r    <= '0;
    end else if (emit) begin
      tile_r <= tile_r + 10'd1;
      if (x_r == ent_r.tx_m1) begin
        x_r <= '0;
        y_r <= y_r + 3'd1;
      end else begin
        x_r <= x_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        act_r <= pop_valid;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `MTMWG_ASSERT(a_last_marked, (emit && last) |=> (out_valid_r && out_data_r.last_write),
                "final write of a meta-tile not marked")
  `MTMWG_ASSERT(a_tile_step, (emit && !last) |=> (tile_r == $past(tile_r) + 10'd1),
                "tile number did not advance by one")
  `MTMWG_ASSERT_IMP(a_walk_range, act_r, (x_r <= ent_r.tx_m1) && (y_r <= ent_r.ty_m1),
                    "sub-tile position beyond the meta-tile")
  `MTMWG_ASSERT_IMP(a_map_range, act_r, (7'(hx) < MAP_X7) && (7'(hy) < MAP_Y7),
                    "wrapped coordinate outside the map")

endmodule

`default_nettype wire

// ----- rtl/meta_tile_map_write_generator_unit.sv -----
// ----------------------------------------------------------------------------
// meta_tile_map_write_generator_unit
// Expands meta-tile draw requests into runs of tile-map entry writes.
// ----------------------------------------------------------------------------
// Each request produces tiles_per_meta_x * tiles_per_meta_y writes (each count
// clamped to 1..8), row-major, one write per cycle from the back walker while
// out_ready is high, and requests follow each other without a gap while the
// queue holds work. The front registers a request, then computes the base
// position and first tile, then wraps the base position into the map, and
// runs alongside the walker through a two-entry queue. Registers may be
// written only while no request is in flight.
`default_nettype none

module meta_tile_map_write_generator_unit #(
  parameter int MAP_TILES_X  = 64,
  parameter int MAP_TILES_Y  = 64,
  parameter int QUADS_ACROSS = 2
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire mtmwg_pkg::req_t                      in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output mtmwg_pkg::res_t                           out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [mtmwg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mtmwg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtmwg_pkg::*;

  logic [3:0] tiles_x_r;
  logic [3:0] tiles_y_r;
  logic       quad_r;

  logic       push_valid;
  logic       push_ready;
  entry_t     push_data;
  logic       pop_valid;
  logic       pop_ready;
  entry_t     pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_x_r <= 4'd2;
      tiles_y_r <= 4'd2;
      quad_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TILES_X: tiles_x_r <= cfg_data[3:0];
        CFG_TILES_Y: tiles_y_r <= cfg_data[3:0];
        CFG_QUAD:    quad_r    <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  mtmwg_front #(
    .MAP_TILES_X (MAP_TILES_X),
    .MAP_TILES_Y (MAP_TILES_Y)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .tiles_x     (tiles_x_r),
    .tiles_y     (tiles_y_r),
    .quad_layout (quad_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  mtmwg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mtmwg_back #(
    .MAP_TILES_X  (MAP_TILES_X),
    .MAP_TILES_Y  (MAP_TILES_Y),
    .QUADS_ACROSS (QUADS_ACROSS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/sv/mtmwg_write_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile-map write checker
// Watches the request, write and register ports of the meta-tile map write
// generator. For every accepted request it works out the full row-major run
// of map writes and queues them. Each write that leaves the block is then
// compared field by field with the oldest queued write.
// ----------------------------------------------------------------------------
module mtmwg_write_checker #(
  parameter int MAP_TILES_X  = 64,
  parameter int MAP_TILES_Y  = 64,
  parameter int QUADS_ACROSS = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  mtmwg_pkg::req_t                  in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  mtmwg_pkg::res_t                  out_data,
  input  logic                             cfg_we,
  input  logic [mtmwg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtmwg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               mismatch_count,
  output int                               writes_outstanding,
  output int                               writes_checked
);
  import mtmwg_pkg::*;

  localparam int MAX_SPAN    = 8;

  logic [3:0] cols_reg;
  logic [3:0] rows_reg;
  logic       quad_reg;
  res_t       pending_writes[$];
  int         fails;
  int         checked;

  initial begin
    mismatch_count     = 0;
    writes_outstanding = 0;
    writes_checked     = 0;
    fails              = 0;
    checked            = 0;
  end

  // Out-of-range counts are pulled back into 1..8.
  function automatic logic [31:0] span_of(input logic [3:0] v);
    logic [31:0] s;
    s = {28'd0, v};
    if (s == 0) begin
      s = 1;
    end else if (s > MAX_SPAN) begin
      s = MAX_SPAN;
    end
    return s;
  endfunction

  function automatic void queue_tile_writes(input req_t r);
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] total;
    logic [31:0] bcol;
    logic [31:0] brow;
    logic [31:0] hx;
    logic [31:0] hy;
    logic [31:0] quad;
    logic [31:0] addr;
    logic [31:0] tile;
    res_t        w;
    int          n;
    tx    = span_of(cols_reg);
    ty    = span_of(rows_reg);
    total = tx * ty;
    bcol  = ({26'd0, r.meta_col} * tx) % MAP_TILES_X;
    brow  = ({26'd0, r.meta_row} * ty) % MAP_TILES_Y;
    tile  = ({22'd0, r.meta_number} * total) & 32'h3FF;
    n     = 0;
    for (int y = 0; y < ty; y++) begin
      for (int x = 0; x < tx; x++) begin
        hx = (bcol + x) % MAP_TILES_X;
        hy = (brow + y) % MAP_TILES_Y;
        if (quad_reg) begin
          quad = (hy / QUAD_TILES) * QUADS_ACROSS + hx / QUAD_TILES;
          addr = quad * QUAD_TILES * QUAD_TILES
               + (hy % QUAD_TILES) * QUAD_TILES + hx % QUAD_TILES;
        end else begin
          addr = hy * MAP_TILES_X + hx;
        end
        w.entry_address = addr[11:0];
        w.tile_number   = tile[9:0];
        w.last_write    = (n + 1 == total);
        pending_writes.push_back(w);
        n++;
        tile = (tile + 1) & 32'h3FF;
      end
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      cols_reg = 4'd2;
      rows_reg = 4'd2;
      quad_reg = 1'b0;
      pending_writes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TILES_X: cols_reg = cfg_data[3:0];
          CFG_TILES_Y: rows_reg = cfg_data[3:0];
          CFG_QUAD:    quad_reg = cfg_data[0];
          default: ;  // drop writes to unmapped registers
        endcase
      end

      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          fails++;
          $display("%0t: unexpected write: expected none, got addr %0d tile %0d last %0d",
                   $time, out_data.entry_address, out_data.tile_number,
                   out_data.last_write);
        end else begin
          want = pending_writes.pop_front();
          checked++;
          if (out_data.entry_address !== want.entry_address ||
              out_data.tile_number !== want.tile_number ||
              out_data.last_write !== want.last_write) begin
            fails++;
            $display("%0t: mismatch: exp addr %0d tile %0d last %0d, got %0d %0d %0d",
                     $time, want.entry_address, want.tile_number, want.last_write,
                     out_data.entry_address, out_data.tile_number,
                     out_data.last_write);
          end
        end
      end

      if (in_valid && in_ready) begin
        queue_tile_writes(in_data);
      end
    end

    // Publish after the edge so the stimulus side reads a settled count.
    mismatch_count     <= fails;
    writes_outstanding <= pending_writes.size();
    writes_checked     <= checked;
  end

endmodule

// ----- tb/sv/meta_tile_map_write_generator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meta-tile map write generator testbench
// Drives draw requests and register settings into the block, stalls the
// write port at random and leaves prediction and comparison to the checker.
// A directed pass covers field extremes, clamped counts, map wrap, tile
// number overflow, both layouts and an unmapped register; random phases
// follow under changing settings.
// ----------------------------------------------------------------------------
module meta_tile_map_write_generator_unit_tb;
  import mtmwg_pkg::*;

  localparam int MAP_TILES_X     = 64;
  localparam int MAP_TILES_Y     = 64;
  localparam int QUADS_ACROSS    = 2;
  localparam int RANDOM_REQUESTS = 220;
  localparam int CALM_TAIL       = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  req_t                  in_data;
  logic                  out_valid;
  logic                  out_ready;
  res_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int writes_outstanding;
  int writes_checked;

  bit idle_on;
  int stall_left;
  int requests_sent;
  int random_sent;
  int settings_used;

  always #6 clk = ~clk;

  meta_tile_map_write_generator_unit #(
    .MAP_TILES_X  (MAP_TILES_X),
    .MAP_TILES_Y  (MAP_TILES_Y),
    .QUADS_ACROSS (QUADS_ACROSS)
  ) u_dut (.*);

  mtmwg_write_checker #(
    .MAP_TILES_X  (MAP_TILES_X),
    .MAP_TILES_Y  (MAP_TILES_Y),
    .QUADS_ACROSS (QUADS_ACROSS)
  ) u_checker (.*);

  // Write port back-pressure: random bursts of stalls while idle_on is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layout(input logic [3:0] tx, input logic [3:0] ty, input logic quad);
    logic [31:0] r32;
    r32 = $urandom;
    write_reg(CFG_TILES_X, tx);
    write_reg(CFG_TILES_Y, ty);
    // upper data bits are don't-care for the layout bit
    write_reg(CFG_QUAD, {r32[2:0], quad});
    settings_used++;
  endtask

  task automatic send_request(input logic [9:0] num, input logic [5:0] col,
                              input logic [5:0] row);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data.meta_number <= num;
    in_data.meta_col    <= col;
    in_data.meta_row    <= row;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Hold until every predicted write has left, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (writes_outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [31:0] r32;
    logic [3:0]  tx;
    logic [3:0]  ty;
    logic [9:0]  num;
    logic [5:0]  col;
    logic [5:0]  row;
    bit          calm;
    int          burst;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    out_ready     = 1'b0;
    rst_n         = 1'b0;
    idle_on       = 1'b0;
    stall_left    = 0;
    requests_sent = 0;
    random_sent   = 0;
    settings_used = 1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on <= 1'b1;

    // reset settings: 2x2, linear; last request overflows the tile number
    send_request(10'd0,   6'd0,  6'd0);
    send_request(10'd341, 6'd42, 6'd21);
    send_request(10'd682, 6'd21, 6'd42);
    send_request(10'd1023, 6'd63, 6'd63);
    wait_drained();

    // largest meta-tile, quadrant layout, starting at the edge of the right quadrant
    set_layout(4'd8, 4'd8, 1'b1);
    send_request(10'd0,    6'd4,  6'd3);
    send_request(10'd682,  6'd21, 6'd42);
    send_request(10'd1023, 6'd63, 6'd63);
    wait_drained();

    // zero and oversize counts are clamped to 1 and 8
    set_layout(4'd0, 4'd15, 1'b0);
    send_request(10'd5,    6'd63, 6'd7);
    send_request(10'd1023, 6'd0,  6'd63);
    send_request(10'd341,  6'd42, 6'd21);
    wait_drained();

    // odd sizes so that runs wrap at the map edges
    set_layout(4'd3, 4'd5, 1'b1);
    send_request(10'd700,  6'd21, 6'd12);
    send_request(10'd1023, 6'd63, 6'd63);
    wait_drained();

    // an unmapped register must leave the settings alone
    write_reg(CFG_SPARE, 4'hF);
    write_reg(CFG_SPARE, 4'h0);
    send_request(10'd2,   6'd21, 6'd60);
    send_request(10'd512, 6'd10, 6'd6);
    wait_drained();

    set_layout(4'd9, 4'd1, 1'b1);
    send_request(10'd128, 6'd31, 6'd33);
    send_request(10'd1023, 6'd63, 6'd0);
    wait_drained();

    set_layout(4'd1, 4'd1, 1'b0);
    send_request(10'd0,    6'd0,  6'd0);
    send_request(10'd1023, 6'd63, 6'd63);
    send_request(10'd341,  6'd42, 6'd21);
    wait_drained();

    while (random_sent < RANDOM_REQUESTS) begin
      calm = (random_sent >= RANDOM_REQUESTS - CALM_TAIL);
      r32  = $urandom;
      // mostly legal counts, now and then a clamped one
      tx = (r32[4:2] == 3'd0) ? r32[11:8]  : {1'b0, r32[14:12]} + 4'd1;
      ty = (r32[7:5] == 3'd0) ? r32[19:16] : {1'b0, r32[22:20]} + 4'd1;
      idle_on <= !calm && (r32[27:26] != 2'd0);
      set_layout(tx, ty, r32[24]);
      if (r32[31:29] == 3'd0) begin
        write_reg(CFG_SPARE, r32[15:12]);
      end
      burst = $urandom_range(8, 30);
      repeat (burst) begin
        r32 = $urandom;
        num = r32[9:0];
        col = r32[15:10];
        row = r32[21:16];
        case (r32[25:23])
          3'd0: col = r32[26] ? 6'd63 : 6'd0;
          3'd1: row = r32[26] ? 6'd63 : 6'd0;
          3'd2: num = r32[26] ? 10'd1023 : 10'd0;
          default: ;
        endcase
        send_request(num, col, row);
        random_sent++;
      end
      wait_drained();
    end

    // catch any stray write after the last run
    repeat (20) @(posedge clk);
    $display("Sent %0d draw requests under %0d register settings.",
             requests_sent, settings_used);
    $display("Checked %0d map writes, %0d mismatches.", writes_checked, mismatch_count);
    if (mismatch_count == 0 && writes_outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d map writes still outstanding.", writes_outstanding);
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mtmwg_pkg.sv
rtl/mtmwg_front.sv
rtl/mtmwg_queue.sv
rtl/mtmwg_back.sv
rtl/meta_tile_map_write_generator_unit.sv
tb/sv/mtmwg_write_checker.sv
tb/sv/meta_tile_map_write_generator_unit_tb.sv
